/* design/ida_pkg.sv */
// Package for the intersubband dipole accumulator.
// Field widths, fixed-point constants and the queue entry type; no dependencies.
`default_nettype none
package ida_pkg;

   localparam int PSI_W   = 18;
   localparam int EDGE_W  = 24;
   localparam int MASS_W  = 18;
   localparam int GAP_W   = 23;
   localparam int E_W     = 24;
   localparam int SCALE_W = 32;
   localparam int S_W     = 26;            // gap + energy - band edge, signed
   localparam int D_W     = 43;            // mass * S
   localparam int NUM_W   = 64;            // gap * 2^40 + d / 2
   localparam int SHIFT_W = 40;
   localparam int Q_W     = 31;            // inverse mass quotient bits
   localparam int INV_W   = 32;            // sum of two inverse masses
   localparam int P_W     = 38;            // signed product of psi sum and delta
   localparam int PMAG_W  = 37;
   localparam int AMAG_W  = 41;
   localparam int ALO_W   = 21;
   localparam int PROD_W  = 78;
   localparam int TMAG_W  = 46;
   localparam int ACC_W   = 40;            // accumulator width
   localparam int OUT_W   = 40;
   localparam int CMP_W   = ((ACC_W > TMAG_W) ? ACC_W : TMAG_W) + 1;
   localparam int CNT_W   = 5;             // divider step counter

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_ENERGY_M   = 2'd0;
   localparam logic [1:0] REG_ENERGY_N   = 2'd1;
   localparam logic [1:0] REG_PAIR_SCALE = 2'd2;

   // One classified grid point waiting for the back end.
   typedef struct packed {
      logic                     pair;       // a previous point exists
      logic [MASS_W-1:0]        mass;
      logic [GAP_W-1:0]         gap;
      logic signed [S_W-1:0]    s_m;
      logic signed [S_W-1:0]    s_n;
      logic signed [P_W-1:0]    prod;
      logic                     last;
   } ida_entry_type;

endpackage
`default_nettype wire

/* design/intersubband_dipole_accumulator.sv */
// Intersubband dipole accumulator: top level with the register port.
// A paired grid point holds the back end through multiply, check, the two 31-step
// serial dividers, scaling, product, rounding and accumulation; an unpaired point
// goes to the result step, a bad-mass one after the check. For a last point out of
// the 2-entry queue, the result is registered there once any earlier one is taken.
// Synchronous reset clears all control, accumulator and register state.
`default_nettype none
module intersubband_dipole_accumulator (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire [3:0]                          paddr,
   input  wire [31:0]                         pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire signed [ida_pkg::PSI_W-1:0]    req_psi_m,
   input  wire signed [ida_pkg::PSI_W-1:0]    req_psi_n,
   input  wire signed [ida_pkg::EDGE_W-1:0]   req_band_edge,
   input  wire [ida_pkg::MASS_W-1:0]          req_mass_rel,
   input  wire [ida_pkg::GAP_W-1:0]           req_gap,
   input  wire                                req_last_point,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [ida_pkg::OUT_W-1:0]   rsp_dipole_angstrom,
   output logic                               rsp_saturated,
   output logic                               rsp_bad_mass
);
   import ida_pkg::*;

   logic signed [E_W-1:0]      energy_m_ff, energy_n_ff;
   logic signed [SCALE_W-1:0]  scale_ff;
   logic                       wr_en;
   logic                       push, full, pop, empty;
   ida_entry_type              push_data, head;

   // Register writes and reads.
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      case (paddr[3:2])
         REG_ENERGY_M:   prdata = 32'(unsigned'(energy_m_ff));
         REG_ENERGY_N:   prdata = 32'(unsigned'(energy_n_ff));
         REG_PAIR_SCALE: prdata = unsigned'(scale_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_m_ff <= '0;
         energy_n_ff <= '0;
         scale_ff    <= '0;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_ENERGY_M:   energy_m_ff <= pwdata[E_W-1:0];
            REG_ENERGY_N:   energy_n_ff <= pwdata[E_W-1:0];
            REG_PAIR_SCALE: scale_ff    <= pwdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ida_front front (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_ready (req_ready),
      .req_psi_m (req_psi_m), .req_psi_n (req_psi_n),
      .req_band_edge (req_band_edge), .req_mass_rel (req_mass_rel),
      .req_gap (req_gap), .req_last_point (req_last_point),
      .energy_m (energy_m_ff), .energy_n (energy_n_ff),
      .queue_full (full), .push (push), .push_data (push_data)
   );

   ida_queue queue (
      .clock (clock), .reset (reset),
      .push (push), .push_data (push_data), .full (full),
      .pop (pop), .head (head), .empty (empty)
   );

   ida_back back (
      .clock (clock), .reset (reset),
      .queue_empty (empty), .head (head), .pop (pop),
      .pair_scale (scale_ff),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready),
      .rsp_dipole_angstrom (rsp_dipole_angstrom),
      .rsp_saturated (rsp_saturated), .rsp_bad_mass (rsp_bad_mass)
   );

endmodule
`default_nettype wire

/* design/ida_div.sv */
// Serial restoring divider giving a 31-bit quotient, one bit per cycle.
// Uses ida_pkg widths. The caller checks that the quotient fits.
`default_nettype none
module ida_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [ida_pkg::NUM_W-1:0]     num,
   input  wire [ida_pkg::D_W-1:0]       den,
   output logic                         done,
   output logic [ida_pkg::Q_W-1:0]      quo
);
   import ida_pkg::*;

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [D_W:0]         rem_ff, rem_in;
   logic [Q_W-1:0]       low_ff, low_in;
   logic [Q_W-1:0]       quo_ff, quo_in;
   logic [D_W-1:0]       den_ff, den_in;
   logic                 done_ff, done_in;
   logic [D_W:0]         trial;

   // One quotient bit per cycle from the shifted remainder.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      trial   = {rem_ff[D_W-1:0], low_ff[Q_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(Q_W - 1);
         rem_in  = (D_W+1)'(num[NUM_W-1:Q_W]);
         low_in  = num[Q_W-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         low_in = {low_ff[Q_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

/* design/ida_queue.sv */
// Two-entry queue of classified grid points between front and back end.
// Uses ida_pkg::ida_entry_type.
`default_nettype none
module ida_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire ida_pkg::ida_entry_type  push_data,
   output logic                         full,
   input  wire                          pop,
   output ida_pkg::ida_entry_type       head,
   output logic                         empty
);
   import ida_pkg::*;

   ida_entry_type  slot_ff [2];
   logic           wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]     count_ff, count_in;

   // Pointer and occupancy update.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ff];

endmodule
`default_nettype wire

/* design/ida_front.sv */
// Front end: accepts grid points, pairs each with the previous one and
// classifies it into a queue entry. Uses ida_pkg.
`default_nettype none
module ida_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire signed [ida_pkg::PSI_W-1:0]  req_psi_m,
   input  wire signed [ida_pkg::PSI_W-1:0]  req_psi_n,
   input  wire signed [ida_pkg::EDGE_W-1:0] req_band_edge,
   input  wire [ida_pkg::MASS_W-1:0]        req_mass_rel,
   input  wire [ida_pkg::GAP_W-1:0]         req_gap,
   input  wire                              req_last_point,
   input  wire signed [ida_pkg::E_W-1:0]    energy_m,
   input  wire signed [ida_pkg::E_W-1:0]    energy_n,
   input  wire                              queue_full,
   output logic                             push,
   output ida_pkg::ida_entry_type           push_data
);
   import ida_pkg::*;

   logic signed [PSI_W-1:0]   prev_psi_m_ff, prev_psi_n_ff;
   logic signed [EDGE_W-1:0]  prev_edge_ff;
   logic [MASS_W-1:0]         prev_mass_ff;
   logic [GAP_W-1:0]          prev_gap_ff;
   logic                      have_prev_ff, have_prev_in;
   logic signed [PSI_W:0]     psum, pdel;
   logic signed [S_W-1:0]     gap_s;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // Pair terms: nonparabolic denominators and the psi product.
   always_comb begin
      psum  = (PSI_W+1)'(prev_psi_m_ff) + (PSI_W+1)'(req_psi_m);
      pdel  = (PSI_W+1)'(req_psi_n) - (PSI_W+1)'(prev_psi_n_ff);
      gap_s = S_W'(signed'({1'b0, prev_gap_ff}));
      push_data.pair = have_prev_ff;
      push_data.mass = prev_mass_ff;
      push_data.gap  = prev_gap_ff;
      push_data.s_m  = gap_s + S_W'(energy_m) - S_W'(prev_edge_ff);
      push_data.s_n  = gap_s + S_W'(energy_n) - S_W'(prev_edge_ff);
      push_data.prod = P_W'(psum) * P_W'(pdel);
      push_data.last = req_last_point;
   end

   // The last point of a profile ends the pairing.
   always_comb begin
      have_prev_in = have_prev_ff;
      if (push) begin
         have_prev_in = !req_last_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         prev_psi_m_ff <= '0;
         prev_psi_n_ff <= '0;
         prev_edge_ff  <= '0;
         prev_mass_ff  <= '0;
         prev_gap_ff   <= '0;
      end else begin
         have_prev_ff <= have_prev_in;
         if (push) begin
            prev_psi_m_ff <= req_psi_m;
            prev_psi_n_ff <= req_psi_n;
            prev_edge_ff  <= req_band_edge;
            prev_mass_ff  <= req_mass_rel;
            prev_gap_ff   <= req_gap;
         end
      end
   end

endmodule
`default_nettype wire

/* design/ida_back.sv */
// Back end: inverse masses through two serial dividers, scaling, saturating
// accumulation and the result register. Uses ida_pkg and ida_div.
`default_nettype none
module ida_back (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                queue_empty,
   input  wire ida_pkg::ida_entry_type        head,
   output logic                               pop,
   input  wire signed [ida_pkg::SCALE_W-1:0]  pair_scale,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [ida_pkg::OUT_W-1:0]   rsp_dipole_angstrom,
   output logic                               rsp_saturated,
   output logic                               rsp_bad_mass
);
   import ida_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_MUL  = 10'b0000000010,
      ST_CHK  = 10'b0000000100,
      ST_DIV  = 10'b0000001000,
      ST_SCL  = 10'b0000010000,
      ST_TLO  = 10'b0000100000,
      ST_THI  = 10'b0001000000,
      ST_RND  = 10'b0010000000,
      ST_ACC  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] OUT_MAX =
      ACC_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}));
   localparam logic signed [ACC_W-1:0] OUT_MIN =
      ACC_W'(signed'({1'b1, {(OUT_W-1){1'b0}}}));
   localparam logic [Q_W-1:0] INV_MAX = {Q_W{1'b1}};

   state_type                state_ff, state_in;
   ida_entry_type            ent_ff, ent_in;
   logic [D_W-1:0]           dm_ff, dm_in, dn_ff, dn_in;
   logic                     clm_ff, clm_in, cln_ff, cln_in;
   logic [AMAG_W-1:0]        amag_ff, amag_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [TMAG_W-1:0]        tmag_ff, tmag_in;
   logic signed [ACC_W-1:0]  sum_ff, sum_in;
   logic                     sat_ff, sat_in, massf_ff, massf_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  out_sum_ff, out_sum_in;
   logic                     out_sat_ff, out_sat_in, out_mass_ff, out_mass_in;

   logic                     ok_m, ok_n, div_start, done_m, done_n;
   logic [NUM_W-1:0]         num_m, num_n;
   logic [Q_W-1:0]           quo_m, quo_n;
   logic [INV_W-1:0]         inv_sum;
   logic [SCALE_W-1:0]       smag;
   logic [PMAG_W-1:0]        pmag;
   logic                     neg;
   logic [CMP_W-1:0]         tmag_c, lim_c, tcl;
   logic signed [ACC_W:0]    term, sum_w;
   logic signed [ACC_W-1:0]  res;
   logic                     res_sat;

   ida_div div_m (
      .clock (clock), .reset (reset), .start (div_start),
      .num (num_m), .den (dm_ff), .done (done_m), .quo (quo_m)
   );

   ida_div div_n (
      .clock (clock), .reset (reset), .start (div_start),
      .num (num_n), .den (dn_ff), .done (done_n), .quo (quo_n)
   );

   // Operand conditioning shared by several steps.
   always_comb begin
      ok_m  = (ent_ff.mass != '0) && (ent_ff.gap != '0) && (ent_ff.s_m > 0);
      ok_n  = (ent_ff.mass != '0) && (ent_ff.gap != '0) && (ent_ff.s_n > 0);
      num_m = {ent_ff.gap, {SHIFT_W{1'b0}}} + NUM_W'(dm_ff >> 1);
      num_n = {ent_ff.gap, {SHIFT_W{1'b0}}} + NUM_W'(dn_ff >> 1);
      inv_sum = INV_W'(clm_ff ? INV_MAX : quo_m) + INV_W'(cln_ff ? INV_MAX : quo_n);
      smag  = pair_scale[SCALE_W-1] ? SCALE_W'(-pair_scale) : SCALE_W'(pair_scale);
      pmag  = ent_ff.prod[P_W-1] ? PMAG_W'(-ent_ff.prod) : PMAG_W'(ent_ff.prod);
      neg   = pair_scale[SCALE_W-1] != ent_ff.prod[P_W-1];
      tmag_c = CMP_W'(tmag_ff);
      lim_c  = neg ? CMP_W'(unsigned'(ACC_MAX)) + 1'b1 : CMP_W'(unsigned'(ACC_MAX));
      tcl    = (tmag_c > lim_c) ? lim_c : tmag_c;
      term   = neg ? -signed'(tcl[ACC_W:0]) : signed'(tcl[ACC_W:0]);
      sum_w  = {sum_ff[ACC_W-1], sum_ff} + term;
      res_sat = 1'b0;
      res     = sum_ff;
      if (sum_ff > OUT_MAX) begin
         res     = OUT_MAX;
         res_sat = 1'b1;
      end else if (sum_ff < OUT_MIN) begin
         res     = OUT_MIN;
         res_sat = 1'b1;
      end
   end

   // Sequencer for one grid point.
   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      dm_in        = dm_ff;
      dn_in        = dn_ff;
      clm_in       = clm_ff;
      cln_in       = cln_ff;
      amag_in      = amag_ff;
      prod_in      = prod_ff;
      tmag_in      = tmag_ff;
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      massf_in     = massf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_sum_in   = out_sum_ff;
      out_sat_in   = out_sat_ff;
      out_mass_in  = out_mass_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop    = 1'b1;
               ent_in = head;
               state_in = head.pair ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            dm_in = D_W'(ent_ff.mass) * D_W'(ent_ff.s_m[S_W-2:0]);
            dn_in = D_W'(ent_ff.mass) * D_W'(ent_ff.s_n[S_W-2:0]);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // A quotient at or above 2^31 clamps to the largest inverse mass.
            clm_in = ok_m && ((NUM_W+Q_W)'(num_m) >= {dm_ff, {Q_W{1'b0}}});
            cln_in = ok_n && ((NUM_W+Q_W)'(num_n) >= {dn_ff, {Q_W{1'b0}}});
            if (clm_in || cln_in) begin
               sat_in = 1'b1;
            end
            if (ok_m && ok_n) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               massf_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (done_m && done_n) begin
               state_in = ST_SCL;
            end
         end
         ST_SCL: begin
            amag_in = AMAG_W'(((SCALE_W+INV_W+1)'(smag) * (SCALE_W+INV_W+1)'(inv_sum)
                      + (SCALE_W+INV_W+1)'(1 << 23)) >> 24);
            state_in = ST_TLO;
         end
         ST_TLO: begin
            prod_in  = PROD_W'(amag_ff[ALO_W-1:0]) * PROD_W'(pmag);
            state_in = ST_THI;
         end
         ST_THI: begin
            prod_in  = ((PROD_W'(amag_ff[AMAG_W-1:ALO_W]) * PROD_W'(pmag)) << ALO_W)
                       + prod_ff;
            state_in = ST_RND;
         end
         ST_RND: begin
            tmag_in  = TMAG_W'(((PROD_W+1)'(prod_ff) + (PROD_W+1)'(64'd1 << 32)) >> 33);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (tmag_ff != '0) begin
               if (tmag_c > lim_c) begin
                  sat_in = 1'b1;
               end
               if (sum_w > (ACC_W+1)'(ACC_MAX)) begin
                  sum_in = ACC_MAX;
                  sat_in = 1'b1;
               end else if (sum_w < (ACC_W+1)'(ACC_MIN)) begin
                  sum_in = ACC_MIN;
                  sat_in = 1'b1;
               end else begin
                  sum_in = sum_w[ACC_W-1:0];
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!ent_ff.last) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_sum_in   = res[OUT_W-1:0];
               out_sat_in   = sat_ff || res_sat;
               out_mass_in  = massf_ff;
               sum_in       = '0;
               sat_in       = 1'b0;
               massf_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         massf_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         massf_ff     <= massf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff      <= ent_in;
      dm_ff       <= dm_in;
      dn_ff       <= dn_in;
      clm_ff      <= clm_in;
      cln_ff      <= cln_in;
      amag_ff     <= amag_in;
      prod_ff     <= prod_in;
      tmag_ff     <= tmag_in;
      out_sum_ff  <= out_sum_in;
      out_sat_ff  <= out_sat_in;
      out_mass_ff <= out_mass_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_dipole_angstrom = out_sum_ff;
   assign rsp_saturated       = out_sat_ff;
   assign rsp_bad_mass        = out_mass_ff;

endmodule
`default_nettype wire
